### hw/rtl/pcc_pkg.sv
// Shared types, codes and helpers for the palette color cycler.
package pcc_pkg;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned PTR_W      = 9;
  localparam int unsigned MAX_COUNT  = 256;

  typedef enum logic [2:0] {
    CMD_WRITE    = 3'd0,
    CMD_LOAD     = 3'd1,
    CMD_TICK     = 3'd2,
    CMD_TICK_OFS = 3'd3,
    CMD_FREEZE   = 3'd4,
    CMD_CLEAR    = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PALETTE_BASE   = 1'b0,
    REG_ACTIVE_ENTRIES = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_MOD,
    ST_LD_WR,
    ST_T_CHK,
    ST_T_EV,
    ST_T_FWR,
    ST_T_OUT,
    ST_T_STAT
  } state_e;

  typedef struct packed {
    logic [16:0]        timer;
    logic [15:0]        dur;
    logic [7:0]         start;
    logic [PTR_W-1:0]   rend;
    logic [PTR_W-1:0]   ptr;
    logic [COLOR_W-1:0] shown;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic logic [7:0] clamp_ch(input logic signed [9:0] v);
    logic [7:0] r;
    if (v < 10'sd0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'hFF;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/pcc_ram.sv
// Generic simple dual-port RAM with registered read.
module pcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/palette_color_cycler.sv
// Palette color cycler: command decoder, entry sequencer and output register.
// Every command is accepted in the idle state and decoded in the next cycle; a table write
// then passes the wrap state, and a load the wrap and entry-write states, before the input
// is ready again. A tick checks each entry; a live one passes the update and output states,
// and also the wrap and fetch states if it fetches a new color, then a status item closes it;
// outputs wait while the output register is full; a pointer past the table repeats the wrap.
// Reset disables and unfreezes all entries and clears config.
module palette_color_cycler #(
  parameter int ENTRIES     = 16,
  parameter int TABLE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry, table_addr, color_count, duration, red, green, blue, force_update, freeze_value
  input  logic [pcc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // command
  input  logic [pcc_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // palette_slot, out_red, out_green, out_blue, any_advanced
  output logic [pcc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // write_valid
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import pcc_pkg::*;

  localparam int EW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW   = $clog2(ENTRIES + 1);
  localparam int TAW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MW   = (TAW + 1 > PTR_W) ? TAW + 1 : PTR_W;
  localparam logic [MW-1:0] TD_M = MW'(TABLE_DEPTH);

  state_e state_q, state_d;

  logic [IN_DATA_W-1:0] in_q;
  logic [IN_USER_W-1:0] cmd_raw_q;
  cmd_e                 cmd;

  logic [3:0]         f_ent;
  logic [7:0]         f_addr;
  logic [8:0]         f_count;
  logic [15:0]        f_dur;
  logic signed [8:0]  f_dr, f_dg, f_db;
  logic               f_force, f_fval;

  logic [WW-1:0]      idx_q, idx_d, walk_q, walk_d;
  logic [MW-1:0]      mod_q, mod_d;
  entry_t             work_q, work_d;
  logic               upd_q, upd_d, adv_q, adv_d;
  logic [7:0]         base_q;
  logic [4:0]         active_q;
  logic [ENTRIES-1:0] en_q, en_d, frz_q, frz_d;

  logic               tbl_we, tbl_re;
  logic [COLOR_W-1:0] tbl_rdata;
  logic               ent_we, ent_re;
  logic [EW-1:0]      ent_waddr;
  logic [ENTRY_W-1:0] ent_rdata;

  logic [EW-1:0]      li, ii;
  logic               ent_ok;
  logic [PTR_W-1:0]   cnt_clip;
  entry_t             ev_rd;
  logic signed [16:0] ev_t1;
  logic [PTR_W-1:0]   ev_ptr;
  logic signed [9:0]  sum_r, sum_g, sum_b;

  logic               out_free, out_load;
  logic               m_valid_q;
  logic               o_wv_d, o_wv_q, o_adv_d, o_adv_q, o_last_d, o_last_q;
  logic [7:0]         o_slot_d, o_slot_q;
  logic [COLOR_W-1:0] o_rgb_d, o_rgb_q;

  assign cmd      = cmd_e'(cmd_raw_q);
  assign f_ent    = in_q[3:0];
  assign f_addr   = in_q[11:4];
  assign f_count  = in_q[20:12];
  assign f_dur    = in_q[36:21];
  assign f_dr     = $signed(in_q[45:37]);
  assign f_dg     = $signed(in_q[54:46]);
  assign f_db     = $signed(in_q[63:55]);
  assign f_force  = in_q[64];
  assign f_fval   = in_q[65];

  assign li       = EW'(f_ent);
  assign ii       = idx_q[EW-1:0];
  assign ent_ok   = 32'(f_ent) < 32'(ENTRIES);
  assign cnt_clip = (32'(f_count) > MAX_COUNT) ? PTR_W'(MAX_COUNT) : f_count;

  assign ev_rd    = entry_t'(ent_rdata);
  assign ev_t1    = $signed(ev_rd.timer) - 17'sd1;
  assign ev_ptr   = (ev_rd.ptr >= ev_rd.rend) ? PTR_W'(ev_rd.start) : ev_rd.ptr;

  assign sum_r = $signed({2'b00, work_q.shown[23:16]}) + 10'(f_dr);
  assign sum_g = $signed({2'b00, work_q.shown[15:8]})  + 10'(f_dg);
  assign sum_b = $signed({2'b00, work_q.shown[7:0]})   + 10'(f_db);

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  pcc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (mod_q[TAW-1:0]),
    .wdata_i ({f_dr[7:0], f_dg[7:0], f_db[7:0]}),
    .re_i    (tbl_re),
    .raddr_i (mod_q[TAW-1:0]),
    .rdata_o (tbl_rdata)
  );

  pcc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (work_d),
    .re_i    (ent_re),
    .raddr_i (ii),
    .rdata_o (ent_rdata)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    walk_d    = walk_q;
    mod_d     = mod_q;
    work_d    = work_q;
    upd_d     = upd_q;
    adv_d     = adv_q;
    en_d      = en_q;
    frz_d     = frz_q;
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    ent_we    = 1'b0;
    ent_re    = 1'b0;
    ent_waddr = ii;
    out_load  = 1'b0;
    o_wv_d    = 1'b1;
    o_slot_d  = base_q + 8'(idx_q);
    o_rgb_d   = work_q.shown;
    o_adv_d   = 1'b0;
    o_last_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        case (cmd)
          CMD_WRITE: begin
            mod_d   = MW'(f_addr);
            state_d = ST_MOD;
          end
          CMD_LOAD: begin
            if (!ent_ok) begin
              state_d = ST_IDLE;
            end else if (f_count == '0) begin
              en_d[li]  = 1'b0;
              frz_d[li] = 1'b0;
              state_d   = ST_IDLE;
            end else begin
              mod_d   = MW'(f_addr);
              state_d = ST_MOD;
            end
          end
          CMD_FREEZE: begin
            if (ent_ok) begin
              frz_d[li] = f_fval;
            end
            state_d = ST_IDLE;
          end
          CMD_CLEAR: begin
            en_d    = '0;
            frz_d   = '0;
            state_d = ST_IDLE;
          end
          CMD_TICK, CMD_TICK_OFS: begin
            idx_d   = '0;
            walk_d  = (32'(active_q) < 32'(ENTRIES)) ? WW'(active_q) : WW'(ENTRIES);
            adv_d   = 1'b0;
            state_d = ST_T_CHK;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_MOD: begin
        if (mod_q >= TD_M) begin
          mod_d = mod_q - TD_M;
        end else begin
          case (cmd)
            CMD_WRITE: begin
              tbl_we  = 1'b1;
              state_d = ST_IDLE;
            end
            CMD_LOAD: begin
              tbl_re  = 1'b1;
              state_d = ST_LD_WR;
            end
            default: begin
              tbl_re  = 1'b1;
              state_d = ST_T_FWR;
            end
          endcase
        end
      end
      ST_LD_WR: begin
        work_d.timer = {1'b0, f_dur};
        work_d.dur   = f_dur;
        work_d.start = f_addr;
        work_d.rend  = PTR_W'(f_addr) + cnt_clip;
        work_d.ptr   = PTR_W'(f_addr);
        work_d.shown = tbl_rdata;
        ent_we       = 1'b1;
        ent_waddr    = li;
        en_d[li]     = 1'b1;
        frz_d[li]    = 1'b0;
        state_d      = ST_IDLE;
      end
      ST_T_CHK: begin
        if (idx_q == walk_q) begin
          state_d = ST_T_STAT;
        end else if (en_q[ii] && !frz_q[ii]) begin
          ent_re  = 1'b1;
          state_d = ST_T_EV;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_T_EV: begin
        work_d = ev_rd;
        upd_d  = (cmd == CMD_TICK) && f_force;
        if (ev_t1 <= 17'sd0) begin
          work_d.timer = {1'b0, ev_rd.dur};
          work_d.ptr   = ev_ptr;
          mod_d        = MW'(ev_ptr);
          state_d      = ST_MOD;
        end else begin
          work_d.timer = ev_t1;
          ent_we       = 1'b1;
          state_d      = ST_T_OUT;
        end
      end
      ST_T_FWR: begin
        work_d.shown = tbl_rdata;
        work_d.ptr   = work_q.ptr + 1'b1;
        upd_d        = 1'b1;
        adv_d        = 1'b1;
        ent_we       = 1'b1;
        state_d      = ST_T_OUT;
      end
      ST_T_OUT: begin
        if (cmd == CMD_TICK_OFS) begin
          o_rgb_d = {clamp_ch(sum_r), clamp_ch(sum_g), clamp_ch(sum_b)};
        end
        if (cmd != CMD_TICK_OFS && !upd_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_T_CHK;
        end else if (out_free) begin
          out_load = 1'b1;
          idx_d    = idx_q + 1'b1;
          state_d  = ST_T_CHK;
        end
      end
      ST_T_STAT: begin
        o_wv_d   = 1'b0;
        o_slot_d = '0;
        o_rgb_d  = '0;
        o_adv_d  = adv_q;
        o_last_d = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      walk_q    <= '0;
      upd_q     <= 1'b0;
      adv_q     <= 1'b0;
      en_q      <= '0;
      frz_q     <= '0;
      base_q    <= '0;
      active_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      walk_q  <= walk_d;
      upd_q   <= upd_d;
      adv_q   <= adv_d;
      en_q    <= en_d;
      frz_q   <= frz_d;
      if (cfg_valid_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_PALETTE_BASE:   base_q   <= cfg_data_i;
          REG_ACTIVE_ENTRIES: active_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q      <= s_axis_tdata;
      cmd_raw_q <= s_axis_tuser;
    end
    mod_q  <= mod_d;
    work_q <= work_d;
    if (out_load) begin
      o_wv_q   <= o_wv_d;
      o_slot_q <= o_slot_d;
      o_rgb_q  <= o_rgb_d;
      o_adv_q  <= o_adv_d;
      o_last_q <= o_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = o_wv_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {7'd0, o_adv_q, o_rgb_q[7:0], o_rgb_q[15:8], o_rgb_q[23:16],
                          o_slot_q};

endmodule
